// ----- hw/rtl/ber_tlv_header_parser_macros.svh -----
// assertion macros for the ber tlv header parser
// used by the top level, needs clk_i and rst_ni in scope
`ifndef BER_TLV_HEADER_PARSER_MACROS_SVH
`define BER_TLV_HEADER_PARSER_MACROS_SVH

// same-cycle implication
`define BTLV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTLV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/btlv_pkg.sv -----
// shared types and constants of the ber tlv header parser
// no dependencies
package btlv_pkg;

  localparam int MaxLengthOctetsDef = 4;

  typedef enum logic [2:0] {
    PH_IDENT   = 3'd0,
    PH_TAGNUM  = 3'd1,
    PH_LEN0    = 3'd2,
    PH_LENLONG = 3'd3,
    PH_CONTENT = 3'd4,
    PH_DROP    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_CONTENT = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_TAG_CUT     = 3'd0,
    ERR_LEN_CUT     = 3'd1,
    ERR_INDEFINITE  = 3'd2,
    ERR_TOO_WIDE    = 3'd3,
    ERR_CONTENT_CUT = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  tag_class;
    logic        is_constructed;
    logic [31:0] tag_number;
    logic [31:0] content_length;
    logic [32:0] total_length;
    logic [7:0]  content_byte;
    logic        last_content;
    err_e        error_code;
  } out_beat_t;

  // pipeline control seen by the parse stage
  typedef struct packed {
    logic valid;    // a beat sits in the input register
    logic advance;  // output register can load this cycle
  } pipe_ctl_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } step_res_t;

endpackage

// ----- hw/rtl/btlv_in_stage.sv -----
// input register of the ber tlv header parser
// depends on btlv_pkg
module btlv_in_stage import btlv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_beat_t in_data_i,
  input  logic     advance_i,
  output logic     held_valid_o,
  output in_beat_t held_beat_o
);

  logic     valid_q, valid_d;
  in_beat_t beat_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= in_data_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_beat_o  = beat_q;

endmodule

// ----- hw/rtl/btlv_step.sv -----
// parse state and per-byte decode of the ber tlv header parser
// depends on btlv_pkg
module btlv_step import btlv_pkg::*; #(
  parameter int MaxLengthOctets = MaxLengthOctetsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pipe_ctl_t ctl_i,
  input  in_beat_t  beat_i,
  output step_res_t res_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  class_q, class_d;
  logic        cons_q, cons_d;
  logic [31:0] tag_q, tag_d;
  logic [6:0]  octs_left_q, octs_left_d;
  logic [6:0]  long_octs_q, long_octs_d;
  logic [31:0] clen_q, clen_d;
  logic [31:0] cleft_q, cleft_d;
  logic [7:0]  hbc_q, hbc_d;

  logic [7:0]  b;
  logic        at_end;
  logic        fire;
  logic [7:0]  hbc_inc;
  logic [31:0] cleft_dec;
  logic        do_hdr;
  logic        do_err;
  err_e        err_code;

  assign b       = beat_i.data_byte;
  assign at_end  = beat_i.buffer_end;
  assign fire    = ctl_i.valid && ctl_i.advance;
  assign hbc_inc = (hbc_q == 8'hFF) ? hbc_q : hbc_q + 8'd1;
  assign cleft_dec = cleft_q - 32'd1;

  always_comb begin
    phase_d     = phase_q;
    class_d     = class_q;
    cons_d      = cons_q;
    tag_d       = tag_q;
    octs_left_d = octs_left_q;
    long_octs_d = long_octs_q;
    clen_d      = clen_q;
    cleft_d     = cleft_q;
    hbc_d       = hbc_q;
    do_hdr      = 1'b0;
    do_err      = 1'b0;
    err_code    = ERR_TAG_CUT;
    res_o       = '0;

    case (phase_q)
      PH_TAGNUM: begin
        hbc_d = hbc_inc;
        tag_d = {tag_q[24:0], b[6:0]};
        if (!b[7]) begin
          phase_d = PH_LEN0;
          if (at_end) begin
            do_err   = 1'b1;
            err_code = ERR_LEN_CUT;
          end
        end else if (at_end) begin
          do_err   = 1'b1;
          err_code = ERR_TAG_CUT;
        end
      end
      PH_LEN0: begin
        hbc_d = hbc_inc;
        if (!b[7]) begin
          clen_d = {24'd0, b};
          do_hdr = 1'b1;
        end else begin
          long_octs_d = b[6:0];
          octs_left_d = b[6:0];
          clen_d      = '0;
          if (b[6:0] == 7'd0) begin
            do_err   = 1'b1;
            err_code = ERR_INDEFINITE;
          end else if (at_end) begin
            do_err   = 1'b1;
            err_code = ERR_LEN_CUT;
          end else begin
            phase_d = PH_LENLONG;
          end
        end
      end
      PH_LENLONG: begin
        hbc_d       = hbc_inc;
        octs_left_d = octs_left_q - 7'd1;
        if (long_octs_q <= 7'(MaxLengthOctets)) begin
          clen_d = {clen_q[23:0], b};
        end
        if (octs_left_d != 7'd0) begin
          if (at_end) begin
            do_err   = 1'b1;
            err_code = ERR_LEN_CUT;
          end
        end else if (long_octs_q > 7'(MaxLengthOctets)) begin
          do_err   = 1'b1;
          err_code = ERR_TOO_WIDE;
        end else begin
          do_hdr = 1'b1;
        end
      end
      PH_CONTENT: begin
        cleft_d = cleft_dec;
        if (at_end && cleft_dec != 32'd0) begin
          do_err   = 1'b1;
          err_code = ERR_CONTENT_CUT;
        end else begin
          res_o.valid             = 1'b1;
          res_o.beat.kind         = KIND_CONTENT;
          res_o.beat.content_byte = b;
          res_o.beat.last_content = (cleft_dec == 32'd0);
          if (cleft_dec == 32'd0) begin
            phase_d = PH_IDENT;
          end
        end
      end
      PH_DROP: begin
        if (at_end) begin
          phase_d = PH_IDENT;
        end
      end
      default: begin
        // identifier octet
        class_d     = b[7:6];
        cons_d      = b[5];
        hbc_d       = 8'd1;
        clen_d      = '0;
        octs_left_d = '0;
        long_octs_d = '0;
        if (b[4:0] == 5'h1F) begin
          tag_d   = '0;
          phase_d = PH_TAGNUM;
          if (at_end) begin
            do_err   = 1'b1;
            err_code = ERR_TAG_CUT;
          end
        end else begin
          tag_d   = {27'd0, b[4:0]};
          phase_d = PH_LEN0;
          if (at_end) begin
            do_err   = 1'b1;
            err_code = ERR_LEN_CUT;
          end
        end
      end
    endcase

    // header complete, unless the buffer ends with content still owed
    if (do_hdr) begin
      if (at_end && clen_d != 32'd0) begin
        do_err   = 1'b1;
        err_code = ERR_CONTENT_CUT;
      end else begin
        res_o.valid               = 1'b1;
        res_o.beat.kind           = KIND_HEADER;
        res_o.beat.tag_class      = class_q;
        res_o.beat.is_constructed = cons_q;
        res_o.beat.tag_number     = tag_d;
        res_o.beat.content_length = clen_d;
        res_o.beat.total_length   = {25'd0, hbc_d} + {1'b0, clen_d};
        cleft_d = clen_d;
        phase_d = (clen_d == 32'd0) ? PH_IDENT : PH_CONTENT;
      end
    end

    if (do_err) begin
      res_o                 = '0;
      res_o.valid           = 1'b1;
      res_o.beat.kind       = KIND_ERROR;
      res_o.beat.error_code = err_code;
      phase_d = at_end ? PH_IDENT : PH_DROP;
    end

    if (!fire) begin
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDENT;
    end else if (fire) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      class_q     <= class_d;
      cons_q      <= cons_d;
      tag_q       <= tag_d;
      octs_left_q <= octs_left_d;
      long_octs_q <= long_octs_d;
      clen_q      <= clen_d;
      cleft_q     <= cleft_d;
      hbc_q       <= hbc_d;
    end
  end

endmodule

// ----- hw/rtl/btlv_out_stage.sv -----
// result register of the ber tlv header parser
// depends on btlv_pkg
module btlv_out_stage import btlv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  step_res_t res_i,
  output logic      advance_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  logic      valid_q;
  out_beat_t beat_q;

  assign advance_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_i.valid) begin
      beat_q <= res_i.beat;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = beat_q;

endmodule

// ----- hw/rtl/ber_tlv_header_parser.sv -----
// top level of the ber tlv header parser: input register, parse stage, result register
// depends on btlv_pkg, btlv_in_stage, btlv_step, btlv_out_stage and the macros header
//
//   channel | direction | handshake             | payload
//   in      | sink      | in_valid_i/in_ready_o | in_data_i (data_byte, buffer_end)
//   out     | source    | out_valid_o/out_ready_i | out_data_o (one record)
//
// one byte per cycle unless the output stalls; a byte passes input and result register
// the per-byte decode sits between the input register and the result register
// a byte that yields no record still takes one pass through the parse stage
// reset clears the valid bits and returns the parser to expecting an identifier
// a stall on the output backs up through both registers to in_ready_o
`include "ber_tlv_header_parser_macros.svh"

module ber_tlv_header_parser import btlv_pkg::*; #(
  parameter int MaxLengthOctets = MaxLengthOctetsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  // wiring between stages
  logic      advance;
  logic      held_valid;
  in_beat_t  held_beat;
  pipe_ctl_t ctl;
  step_res_t res;

  // terms used by the checks below
  logic      in_stalled;
  logic      hdr_out;
  logic      err_out;
  logic      hdr_total_ok;
  logic      err_clean;

  assign ctl.valid   = held_valid;
  assign ctl.advance = advance;

  // input register, frees up whenever the result register can load
  btlv_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_beat_o  (held_beat)
  );

  // identifier, tag, length and content tracking for one byte
  btlv_step #(
    .MaxLengthOctets (MaxLengthOctets)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .beat_i (held_beat),
    .res_o  (res)
  );

  // result register, loads when empty or being drained
  btlv_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assign in_stalled   = held_valid && !advance;
  assign hdr_out      = out_valid_o && out_data_o.kind == KIND_HEADER;
  assign err_out      = out_valid_o && out_data_o.kind == KIND_ERROR;
  assign hdr_total_ok = out_data_o.total_length >= 33'(out_data_o.content_length) + 33'd2;
  assign err_clean    = out_data_o.error_code <= ERR_CONTENT_CUT &&
                        out_data_o.content_byte == 8'd0;

  // a byte waiting in the input register is not lost or altered by a stall
  `BTLV_ASSERT_NEXT(a_in_hold, in_stalled, held_valid && $stable(held_beat), "stalled byte lost")

  // a header always counts at least two header bytes on top of its content
  `BTLV_ASSERT_NOW(a_hdr_total, hdr_out, hdr_total_ok, "header total length too small")

  // error records carry a defined code and no content
  `BTLV_ASSERT_NOW(a_err_clean, err_out, err_clean, "malformed error record")

endmodule
